// ----- hw/rtl/drs_pkg.sv -----
// dense region suppressor: shared types, register codes and reset values
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package drs_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int DefWindow    = 5;
  localparam int MaxHeight    = 4096;
  localparam int RowW         = 13;
  localparam int QueueDepth   = 4;

  localparam logic [10:0] ResetWidth     = 11'd640;
  localparam logic [12:0] ResetHeight    = 13'd480;
  localparam logic [12:0] ResetThreshold = 13'd2500;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_e;

  // classified stream position handed from front to back
  typedef struct packed {
    logic [7:0] pix;
    logic       flag_ok;
    logic       emit;
    logic       last;
  } drs_item_t;

endpackage

// ----- hw/rtl/drs_front.sv -----
// dense region suppressor front: configuration registers, frame position
// counters and item classification; uses drs_pkg
`timescale 1ns / 1ps

module drs_front #(
  parameter int MAX_WIDTH = drs_pkg::DefMaxWidth,
  parameter int WINDOW    = drs_pkg::DefWindow
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [12:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   pixel_value_i,
  input  logic                         padding_i,
  input  logic                         full_i,
  output logic                         push_o,
  output drs_pkg::drs_item_t           item_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output logic [12:0]                  thresh_o
);
  import drs_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WeffW = $clog2(MAX_WIDTH + 1);

  logic [10:0]      width_q;
  logic [12:0]      height_q;
  logic [12:0]      thresh_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [WeffW-1:0] w_eff;
  logic [RowW-1:0]  h_eff;
  logic             accept, is_real, cfg_hit, row_ge, row_ge1, col_ge;
  drs_item_t        item;

  always_comb begin
    if (width_q < 11'(WINDOW)) begin
      w_eff = WeffW'(WINDOW);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WeffW'(MAX_WIDTH);
    end else begin
      w_eff = WeffW'(width_q);
    end
    if (height_q < 13'(WINDOW)) begin
      h_eff = RowW'(WINDOW);
    end else if (height_q > 13'(MaxHeight)) begin
      h_eff = RowW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i == CFG_FRAME_WIDTH ||
                       cfg_index_i == CFG_FRAME_HEIGHT || cfg_index_i == CFG_THRESHOLD);
  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign is_real     = row_q < h_eff;

  // output row is one further back while the column wraps into the previous row
  assign col_ge  = col_q >= ColW'(WINDOW - 1);
  assign row_ge  = (row_q >= RowW'(WINDOW - 1)) && (row_q < h_eff + RowW'(WINDOW - 1));
  assign row_ge1 = (row_q >= RowW'(WINDOW)) && (row_q < h_eff + RowW'(WINDOW));

  always_comb begin
    item.pix     = is_real ? pixel_value_i : 8'd0;
    item.flag_ok = is_real && col_ge && (row_q >= RowW'(WINDOW - 1));
    item.emit    = col_ge ? row_ge : row_ge1;
    item.last    = (col_q == ColW'(WINDOW - 2)) && (row_q == h_eff + RowW'(WINDOW - 1));
  end

  assign push_o   = accept && !(is_real && padding_i);
  assign item_o   = item;
  assign col_o    = col_q;
  assign thresh_o = thresh_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (push_o) begin
      if (item.last) begin
        col_d = '0;
        row_d = '0;
      end else if (WeffW'(col_q) + WeffW'(1) >= w_eff) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      thresh_q <= ResetThreshold;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[10:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
          CFG_THRESHOLD:    thresh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WeffW'(col_q) < w_eff)
    else $error("column counter beyond frame width");
  a_row_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < h_eff + RowW'(WINDOW))
    else $error("row counter beyond drain rows");
`endif

endmodule

// ----- hw/rtl/drs_queue.sv -----
// dense region suppressor queue: short fifo between front and back
// holds classified items; uses drs_pkg for its depth
`timescale 1ns / 1ps

module drs_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o
);
  import drs_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  logic [DATA_W-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     count_q;

  assign full_o  = count_q == (PtrW + 1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/drs_back.sv -----
// dense region suppressor back: line memory, column and box sums, dense
// flags, suppression and output register; uses drs_pkg
`timescale 1ns / 1ps

module drs_back #(
  parameter int MAX_WIDTH = drs_pkg::DefMaxWidth,
  parameter int WINDOW    = drs_pkg::DefWindow
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  drs_pkg::drs_item_t           q_item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col_i,
  output logic                         pop_o,
  input  logic [12:0]                  thresh_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   result_pixel_o,
  output logic                         frame_last_o
);
  import drs_pkg::*;

  localparam int Taps    = WINDOW - 1;
  localparam int PixBits = Taps * 8;
  localparam int WordW   = PixBits + Taps;
  localparam int AddrW   = $clog2(MAX_WIDTH);
  localparam int ColSumW = $clog2(WINDOW * 255 + 1);
  localparam int BoxW    = $clog2(WINDOW * WINDOW * 255 + 1);
  localparam int CmpW    = (BoxW > 13) ? BoxW : 13;

  logic [WordW-1:0]   line_mem [MAX_WIDTH];
  logic [WordW-1:0]   rd_q, s2_rd_q, wr_word;
  logic               en, s1_adv, s2_adv;
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  drs_item_t          s1_item_q, s2_item_q;
  logic [AddrW-1:0]   s1_col_q, s2_col_q;
  logic [ColSumW-1:0] colsum;
  logic [ColSumW-1:0] cs_q [WINDOW];
  logic [7:0]         p_q [WINDOW];
  logic               fo_q [Taps];
  logic [BoxW-1:0]    box;
  logic               flag, fcol, zero;
  logic [7:0]         result_q;
  logic               last_q;

  assign en     = !(out_valid_q && out_stall_i);
  assign pop_o  = q_valid_i && en;
  assign s1_adv = s1_valid_q && en;
  assign s2_adv = s2_valid_q && en;

  // vertical sum over the current pixel and the rows above it
  always_comb begin
    colsum = ColSumW'(s1_item_q.pix);
    for (int i = 0; i < Taps; i++) begin
      colsum = colsum + ColSumW'(rd_q[8*i +: 8]);
    end
  end

  always_comb begin
    box = '0;
    for (int i = 0; i < WINDOW; i++) begin
      box = box + BoxW'(cs_q[i]);
    end
    flag = s2_item_q.flag_ok && (CmpW'(box) > CmpW'(thresh_i));
    fcol = flag || (|s2_rd_q[PixBits +: Taps]);
    zero = fcol;
    for (int i = 0; i < Taps; i++) begin
      zero = zero || fo_q[i];
    end
    wr_word = {s2_rd_q[PixBits +: Taps - 1], flag,
               s2_rd_q[0 +: PixBits - 8], s2_item_q.pix};
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rd_q <= line_mem[q_col_i];
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) line_mem[s2_col_q] <= wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_item_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= q_item_i;
      s1_col_q  <= q_col_i;
    end
    if (s1_adv) begin
      s2_item_q <= s1_item_q;
      s2_col_q  <= s1_col_q;
      s2_rd_q   <= rd_q;
      cs_q[0]   <= colsum;
      p_q[0]    <= rd_q[8*(Taps-1) +: 8];
      for (int i = 1; i < WINDOW; i++) begin
        cs_q[i] <= cs_q[i-1];
        p_q[i]  <= p_q[i-1];
      end
    end
    if (s2_adv) begin
      fo_q[0] <= fcol;
      for (int i = 1; i < Taps; i++) begin
        fo_q[i] <= fo_q[i-1];
      end
      result_q <= zero ? 8'd0 : p_q[Taps];
      last_q   <= s2_item_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = result_q;
  assign frame_last_o   = last_q;

endmodule

// ----- hw/rtl/dense_region_suppressor_core.sv -----
// Dense region suppressor: streams an 8-bit image in raster order and blanks
// every pixel within two rows and columns of a 5x5 window whose sum exceeds
// density_threshold. One pixel per clock is sustained unless the output
// stalls; the result is registered, and pixel n of the frame leaves with
// stream position n + (WINDOW-1)*(frame_width+1), so the tail is drained
// with padding requests after the last pixel. The rate is set by the line
// memory of MAX_WIDTH words, read at one column and written at another in
// every cycle. The memory needs no clearing pass after reset. Depends on
// drs_pkg, drs_front, drs_queue and drs_back.
`timescale 1ns / 1ps

module dense_region_suppressor_core #(
  parameter int MAX_WIDTH = drs_pkg::DefMaxWidth,
  parameter int WINDOW    = drs_pkg::DefWindow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_value_i,
  input  logic        padding_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  result_pixel_o,
  output logic        frame_last_o
);
  import drs_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int ItemW = $bits(drs_item_t);
  localparam int QW    = ItemW + ColW;

  logic            push, full, q_valid, pop;
  drs_item_t       f_item, q_item;
  logic [ColW-1:0] f_col, q_col;
  logic [12:0]     thresh;
  logic [QW-1:0]   q_out;

  drs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .WINDOW    (WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .padding_i     (padding_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (f_item),
    .col_o         (f_col),
    .thresh_o      (thresh)
  );

  drs_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_item, f_col}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_out)
  );

  assign q_item = drs_item_t'(q_out[QW-1 -: ItemW]);
  assign q_col  = q_out[ColW-1:0];

  drs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .WINDOW    (WINDOW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_col_i        (q_col),
    .pop_o          (pop),
    .thresh_i       (thresh),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_pixel_o (result_pixel_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

// ----- tb/sv/tb_dense_region_suppressor_core.sv -----
// testbench for dense_region_suppressor_core: drives frames through the block,
// predicts every output pixel in place and compares; depends on drs_pkg and the RTL
`timescale 1ns / 1ps

module tb_dense_region_suppressor_core;
  import drs_pkg::*;

  localparam int Win       = 5;
  localparam int MaxW      = 1024;
  localparam int MaxH      = 4096;
  localparam int Half      = (Win - 1) / 2;
  localparam int RingDepth = (Win - 1) * MaxW + Win;
  localparam int DrainWait = 20;
  localparam int CycleLimit = 3000000;
  localparam logic [1:0] CfgUnused = 2'd3;

  typedef struct {
    logic [7:0] pix;
    logic       last;
  } out_pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_value_i = '0;
  logic        padding_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  result_pixel_o;
  logic        frame_last_o;

  dense_region_suppressor_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  line_pix [RingDepth];
  bit          line_flag [RingDepth];
  int          ring_pos, col_pos, row_pos;
  logic [10:0] reg_width;
  logic [12:0] reg_height, reg_thresh;
  bit          frame_done;
  out_pixel_t  pending_pixels [$];

  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  px_lo = 0, px_hi = 255;

  function automatic int eff_w();
    int w;
    w = reg_width;
    if (w < Win) w = Win;
    if (w > MaxW) w = MaxW;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = reg_height;
    if (h < Win) h = Win;
    if (h > MaxH) h = MaxH;
    return h;
  endfunction

  function automatic int back_pos(int d);
    return (ring_pos + RingDepth - (d % RingDepth)) % RingDepth;
  endfunction

  function automatic void predict_pixel(logic [7:0] px, logic pad);
    int w, h, r, c, k, y, x, sum;
    bit real_px, flag, blank, last;
    out_pixel_t o;
    w = eff_w();
    h = eff_h();
    real_px = row_pos < h;
    flag = 0;
    blank = 0;
    last = 0;
    if (real_px && pad) return;
    line_pix[ring_pos] = real_px ? px : 8'd0;
    if (real_px && row_pos >= Win - 1 && col_pos >= Win - 1) begin
      sum = 0;
      for (int a = 0; a < Win; a++)
        for (int b = 0; b < Win; b++) sum += line_pix[back_pos(a * w + b)];
      flag = sum > reg_thresh;
    end
    line_flag[ring_pos] = flag;
    c = col_pos - (Win - 1);
    r = row_pos - (Win - 1);
    if (c < 0) begin
      c += w;
      r -= 1;
    end
    if (r >= 0 && r < h) begin
      k = row_pos * w + col_pos;
      for (int dy = -Half; dy <= Half; dy++)
        for (int dx = -Half; dx <= Half; dx++) begin
          y = r + dy;
          x = c + dx;
          // only centers whose window is fully inside the frame carry a flag
          if (y >= Half && y <= h - 1 - Half && x >= Half && x <= w - 1 - Half)
            if (line_flag[back_pos(k - ((y + Half) * w + x + Half))]) blank = 1;
        end
      last = (r == h - 1) && (c == w - 1);
      o.pix = blank ? 8'd0 : line_pix[back_pos((Win - 1) * (w + 1))];
      o.last = last;
      pending_pixels.push_back(o);
    end
    ring_pos = (ring_pos + 1) % RingDepth;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
      frame_done = 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_pixel_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result_pixel", result_pixel_o, -1);
      end else begin
        e = pending_pixels.pop_front();
        if (result_pixel_o !== e.pix) report_mismatch("result_pixel", result_pixel_o, e.pix);
        if (frame_last_o !== e.last) report_mismatch("frame_last", frame_last_o, e.last);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("tb_dense_region_suppressor_core NOT OK");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] px, logic pad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_value_i <= px;
    padding_i <= pad;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(px, pad);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  reg_width = data[10:0];
      CFG_FRAME_HEIGHT: reg_height = data;
      CFG_THRESHOLD:    reg_thresh = data;
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_frame(int w, int h, int thr);
    write_reg(CFG_FRAME_WIDTH, 13'(w));
    write_reg(CFG_FRAME_HEIGHT, 13'(h));
    write_reg(CFG_THRESHOLD, 13'(thr));
  endtask

  // one whole frame plus its drain; returns the number of requests sent apart from the padding among the frame's pixels
  task automatic send_frame(int pad_pct, int drain_real_pct, output int sent);
    int n;
    sent = 0;
    frame_done = 0;
    n = eff_w() * eff_h();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < pad_pct) send_pixel(8'($urandom), 1'b1);
      send_pixel(8'($urandom_range(px_hi, px_lo)), 1'b0);
      sent++;
    end
    while (!frame_done) begin
      send_pixel(8'($urandom), !($urandom_range(99) < drain_real_pct));
      sent++;
    end
  endtask

  task automatic test_config_restart();
    int s;
    // part of a frame at reset sizes, then a write restarts it
    for (int i = 0; i < 20; i++) send_pixel(8'($urandom), 1'b0);
    write_reg(CfgUnused, 13'h1fff);
    set_frame(6, 5, 2000);
    send_frame(0, 0, s);
  endtask

  task automatic test_thresholds();
    int s;
    px_lo = 255; px_hi = 255;
    set_frame(5, 5, 0);
    send_frame(10, 30, s);
    set_frame(5, 5, 6375);
    send_frame(10, 30, s);
    set_frame(7, 6, 6374);
    send_frame(0, 0, s);
    px_lo = 0; px_hi = 0;
    set_frame(5, 5, 0);
    send_frame(0, 0, s);
    set_frame(6, 7, 8191);
    px_lo = 0; px_hi = 255;
    send_frame(20, 50, s);
  endtask

  task automatic test_clamping();
    int s;
    px_lo = 150; px_hi = 255;
    set_frame(0, 0, 4000);
    send_frame(5, 20, s);
    px_lo = 0; px_hi = 255;
    // oversized height keeps every row real; the frame is cut short by the next write
    set_frame(5, 13'h1fff, 3200);
    for (int i = 0; i < 120; i++) begin
      if ($urandom_range(99) < 5) send_pixel(8'($urandom), 1'b1);
      send_pixel(8'($urandom), 1'b0);
    end
    set_frame(1024, 4096, 2500);
    for (int i = 0; i < 50; i++) send_pixel(8'($urandom), 1'b0);
  endtask

  task automatic test_random(int budget);
    int sent, s, lo;
    sent = 0;
    while (sent < budget) begin
      lo = $urandom_range(255);
      px_lo = lo;
      px_hi = $urandom_range(255, lo);
      set_frame($urandom_range(12, 5), $urandom_range(9, 5), $urandom_range(6375));
      send_frame($urandom_range(10), $urandom_range(30), s);
      sent += s;
    end
  endtask

  initial begin
    for (int i = 0; i < RingDepth; i++) begin
      line_pix[i] = '0;
      line_flag[i] = 0;
    end
    ring_pos = 0;
    col_pos = 0;
    row_pos = 0;
    reg_width = ResetWidth;
    reg_height = ResetHeight;
    reg_thresh = ResetThreshold;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_config_restart();
    test_thresholds();
    test_clamping();
    send_idle_pct = 10; stall_pct = 76;
    test_random(400);
    send_idle_pct = 76; stall_pct = 10;
    test_random(400);
    send_idle_pct = 0; stall_pct = 0;
    test_random(400);
    wait_idle();
    if (errors == 0) $display("tb_dense_region_suppressor_core OK");
    else $display("tb_dense_region_suppressor_core NOT OK");
    $finish;
  end

endmodule
